// ===== src/tfa_pkg.sv =====
`default_nettype none

package tfa_pkg;

    localparam int TAG_W = 5;
    localparam int CNT_W = 13;
    localparam int FRM_W = 12;

    localparam logic [TAG_W-1:0] TAG_FREE = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_BAD  = TAG_W'(7);

    // Largest frame limit that the 13-bit frames_in_use register can express.
    localparam int LIMIT_MAX = (1 << CNT_W) - 1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_RANGE = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOFIT  = 2'd1,
        ST_BADREQ = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]       pad;
        logic [FRM_W-1:0] frame_number;
        logic [TAG_W-1:0] frame_tag;
        logic [CNT_W-1:0] run_length;
    } t_in_data;

    typedef struct packed {
        logic [TAG_W-1:0] tag_read;
        logic [CNT_W-1:0] free_frames;
        logic [FRM_W-1:0] first_frame;
        t_status          status;
    } t_out_data;

endpackage

`default_nettype wire

// ===== src/tagged_frame_first_fit_allocator.sv =====
// Tagged first-fit frame allocator. Every frame carries a 5-bit owner tag (1 is free, 7 is bad)
// held in a single-port-write, single-port-read tag memory, and a counter tracks the free frames.
// One request is worked on at a time and gives exactly one result transfer. After reset the block
// sweeps the tag memory to the bad tag, one frame per cycle, and takes no request until the
// sweep is over; configuration writes are taken throughout. Each tag memory access handles one
// frame per cycle. Free and read touch one frame, tag-range touches run_length frames, and
// allocate scans from frame 0 until a free run fits or the frame limit is reached, then writes
// the run. Rejected requests go straight to the result without touching the tag memory.
// The frame limit is the smaller of frames_in_use and NUM_FRAMES.
`default_nettype none

module tagged_frame_first_fit_allocator
    import tfa_pkg::*;
#(
    parameter int NUM_FRAMES = 4096,
    parameter int TAG_COUNT  = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Request stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // run_length[12:0], frame_tag[17:13], frame_number[29:18], zero[31:30]
    input  wire logic [31:0] i_s_axis_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  i_s_axis_tuser,
    // Result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // status[1:0], first_frame[13:2], free_frames[26:14], tag_read[31:27]
    output logic [31:0]      o_m_axis_tdata,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(NUM_FRAMES);
    localparam int LIM_CAP = (NUM_FRAMES > LIMIT_MAX) ? LIMIT_MAX : NUM_FRAMES;
    localparam logic [CNT_W-1:0] LIM_CAP_W = CNT_W'(LIM_CAP);
    localparam bit ALL_TAGS = (TAG_COUNT >= (1 << TAG_W));
    localparam logic [TAG_W-1:0] TAG_LIM = TAG_W'(TAG_COUNT);
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_FRAMES - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_RMW,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [AW-1:0]    r_clr;
    logic [CNT_W-1:0] r_fiu;
    logic [CNT_W-1:0] r_free;
    logic [CNT_W-1:0] r_lim;
    logic [CNT_W-1:0] r_len;
    logic [TAG_W-1:0] r_tag;
    logic [CNT_W-1:0] r_ptr;
    logic [CNT_W-1:0] r_issue_left;
    logic [CNT_W-1:0] r_left;
    logic             r_dv;
    logic [CNT_W-1:0] r_didx;
    logic [CNT_W-1:0] r_run;
    logic [CNT_W-1:0] r_start;
    logic             r_rdonly;
    t_status          r_res_status;
    logic [FRM_W-1:0] r_res_first;
    logic [TAG_W-1:0] r_res_tag;
    logic             r_out_valid;
    t_out_data        r_out_data;

    logic [TAG_W-1:0] tag_mem [NUM_FRAMES];
    logic [TAG_W-1:0] r_rdata;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [TAG_W-1:0] mem_wd;
    logic [AW-1:0]    mem_ra;

    t_in_data         req;
    t_cmd             cmd;
    logic [CNT_W-1:0] lim;
    logic [CNT_W-1:0] req_frm;
    logic             tag_ok;
    logic             cfg_wr;
    logic             hit;
    logic [CNT_W-1:0] n_run;
    logic [CNT_W-1:0] n_start;
    logic             found;
    logic             scan_last;
    logic             dec_free;
    logic             inc_free;

    assign req     = t_in_data'(i_s_axis_tdata);
    assign cmd     = t_cmd'(i_s_axis_tuser);
    assign lim     = (r_fiu < LIM_CAP_W) ? r_fiu : LIM_CAP_W;
    assign req_frm = CNT_W'(req.frame_number);
    assign tag_ok  = ALL_TAGS || (req.frame_tag < TAG_LIM);

    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_fiu);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // Scan bookkeeping on the tag that came back from the memory this cycle.
    assign hit       = r_dv && (r_rdata == TAG_FREE);
    assign n_run     = r_run + CNT_W'(1);
    assign n_start   = (r_run == '0) ? r_didx : r_start;
    assign found     = hit && (n_run == r_len);
    assign scan_last = (r_didx == r_lim - CNT_W'(1));

    assign dec_free = (r_rdata == TAG_FREE) && (r_tag != TAG_FREE);
    assign inc_free = (r_rdata != TAG_FREE) && (r_tag == TAG_FREE);

    // Reads always follow the issue pointer. Writes in the read-modify-write loop trail the
    // reads by one frame, so a read never meets a pending write to the same frame.
    assign mem_ra = AW'(r_ptr);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = AW'(r_didx);
        mem_wd = r_tag;
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = TAG_BAD;
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_ptr);
            end
            S_RMW: begin
                mem_we = r_dv && !r_rdonly;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            tag_mem[mem_wa] <= mem_wd;
        end
        r_rdata <= tag_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_fiu       <= CNT_W'(4096);
            r_free      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_fiu <= pwdata[CNT_W-1:0];
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_lim        <= lim;
                        r_len        <= req.run_length;
                        r_tag        <= req.frame_tag;
                        r_res_status <= ST_OK;
                        r_res_first  <= '0;
                        r_res_tag    <= '0;
                        r_run        <= '0;
                        r_dv         <= 1'b0;
                        r_rdonly     <= 1'b0;
                        r_ptr        <= req_frm;
                        r_issue_left <= CNT_W'(1);
                        r_left       <= CNT_W'(1);
                        r_state      <= S_DONE;
                        case (cmd)
                            CMD_ALLOC: begin
                                r_ptr <= '0;
                                if (req.run_length == '0 || req.frame_tag == TAG_FREE
                                        || !tag_ok) begin
                                    r_res_status <= ST_BADREQ;
                                end else if (r_free < req.run_length || lim == '0) begin
                                    r_res_status <= ST_NOFIT;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            CMD_FREE: begin
                                r_tag <= TAG_FREE;
                                if (req_frm >= lim) begin
                                    r_res_status <= ST_RANGE;
                                end else begin
                                    r_state <= S_RMW;
                                end
                            end
                            CMD_RANGE: begin
                                r_issue_left <= req.run_length;
                                r_left       <= req.run_length;
                                if (!tag_ok) begin
                                    r_res_status <= ST_BADREQ;
                                end else if (req_frm >= lim
                                        || req.run_length > lim - req_frm) begin
                                    r_res_status <= ST_RANGE;
                                end else if (req.run_length != '0) begin
                                    r_state <= S_RMW;
                                end
                            end
                            CMD_READ: begin
                                r_rdonly <= 1'b1;
                                if (req_frm >= lim) begin
                                    r_res_status <= ST_RANGE;
                                end else begin
                                    r_state <= S_RMW;
                                end
                            end
                            default: begin
                                r_res_status <= ST_BADREQ;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    if (r_ptr < r_lim) begin
                        r_ptr  <= r_ptr + CNT_W'(1);
                        r_dv   <= 1'b1;
                        r_didx <= r_ptr;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv) begin
                        if (found) begin
                            // Every frame of the run was free, so each write drops the count.
                            r_free      <= r_free - r_len;
                            r_ptr       <= n_start;
                            r_left      <= r_len;
                            r_res_first <= n_start[FRM_W-1:0];
                            r_dv        <= 1'b0;
                            r_state     <= S_FILL;
                        end else begin
                            r_run   <= hit ? n_run : '0;
                            r_start <= n_start;
                            if (scan_last) begin
                                r_res_status <= ST_NOFIT;
                                r_dv         <= 1'b0;
                                r_state      <= S_DONE;
                            end
                        end
                    end
                end

                S_FILL: begin
                    r_ptr  <= r_ptr + CNT_W'(1);
                    r_left <= r_left - CNT_W'(1);
                    if (r_left == CNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end

                S_RMW: begin
                    if (r_issue_left != '0) begin
                        r_ptr        <= r_ptr + CNT_W'(1);
                        r_issue_left <= r_issue_left - CNT_W'(1);
                        r_dv         <= 1'b1;
                        r_didx       <= r_ptr;
                    end else begin
                        r_dv <= 1'b0;
                    end
                    if (r_dv) begin
                        if (r_rdonly) begin
                            r_res_tag <= r_rdata;
                        end else if (dec_free) begin
                            r_free <= r_free - CNT_W'(1);
                        end else if (inc_free) begin
                            r_free <= r_free + CNT_W'(1);
                        end
                        r_left <= r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            r_dv    <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end
                end

                S_DONE: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_out_valid            <= 1'b1;
                        r_out_data.status      <= r_res_status;
                        r_out_data.first_frame <= r_res_first;
                        r_out_data.free_frames <= r_free;
                        r_out_data.tag_read    <= r_res_tag;
                        r_state                <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== src/tfa_checker.sv =====
`default_nettype none

module tfa_checker
    import tfa_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic        pready
);

    t_out_data res;

    assign res = t_out_data'(o_m_axis_tdata);

    // The tag memory is swept after every reset, so no request is taken straight away.
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("request taken during the tag memory sweep");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result transfer changed");

    // A failed request reports neither a run start nor a tag.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && res.status != ST_OK |-> res.first_frame == '0 && res.tag_read == '0)
        else $error("failed request carries result data");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("configuration port not ready");

endmodule

bind tagged_frame_first_fit_allocator tfa_checker u_tfa_checker (.*);

`default_nettype wire
